>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SEF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define SEF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sef_pkg.sv
// ----------------------------------------------------------------------------
// sef_pkg
// Shared types and constants of the sliding epoch framer.
// ----------------------------------------------------------------------------
package sef_pkg;

	localparam int CHANNELS      = 4;
	localparam int SAMPLE_W      = 16;
	localparam int TIME_W        = 63;
	localparam int RATE_W        = 16;
	localparam int LEN_W         = 7;
	localparam int STEP_W        = 16;
	localparam int CNT_W         = 32;
	localparam int FILL_W        = 16;
	localparam int FRAC_W        = 32;
	localparam int QUOT_W        = 64;
	localparam int NUM_W         = CNT_W + STEP_W + 1;
	localparam int EPOCH_MAX_DEF = 64;
	localparam int REG_IDX_W     = 2;
	localparam int FRAME_W       = CHANNELS * SAMPLE_W;

	localparam logic [REG_IDX_W-1:0] REG_RATE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEN  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP = 2'd2;

	localparam logic [RATE_W-1:0] RATE_RST = 16'd512;
	localparam logic [LEN_W-1:0]  LEN_RST  = 7'd32;
	localparam logic [STEP_W-1:0] STEP_RST = 16'd16;

	typedef logic [FRAME_W-1:0] frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV0,
		ST_DIV1,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
	} div_req_t;

endpackage

>>> sv/sef_div.sv
// ----------------------------------------------------------------------------
// sef_div
// Bit-serial divider: floor((num << 32) / divisor), low 64 quotient bits.
// ----------------------------------------------------------------------------
module sef_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sef_pkg::div_req_t         req,
	input  logic [sef_pkg::RATE_W-1:0] divisor,
	output logic                      done,
	output logic [sef_pkg::QUOT_W-1:0] quot
);
	import sef_pkg::*;

	localparam int DIV_BITS = NUM_W + FRAC_W;
	localparam int DC_W     = $clog2(DIV_BITS);

	logic [DIV_BITS-1:0] num_q;
	logic [RATE_W-1:0]   rem_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [DC_W-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [RATE_W:0] trial;
	logic            ge;
	logic [RATE_W:0] diff;

	always_comb begin
		trial = {rem_q, num_q[DIV_BITS-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {req.num, {FRAC_W{1'b0}}};
			rem_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_BITS-2:0], 1'b0};
			rem_q  <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> sv/sef_store.sv
// ----------------------------------------------------------------------------
// sef_store
// Frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sef_store #(
	parameter int DEPTH = sef_pkg::EPOCH_MAX_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  sef_pkg::frame_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output sef_pkg::frame_t rdata
);
	import sef_pkg::*;

	frame_t mem [DEPTH];
	frame_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/sliding_epoch_framer.sv
// ----------------------------------------------------------------------------
// sliding_epoch_framer
// Cuts a multichannel frame stream into overlapping or skipping epochs and
// emits each full epoch with 31.32 start and end time stamps.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// input   | in_valid / in_ready | sample_ch0..3, first_of_chunk, chunk times
// output  | out_valid/out_ready | epoch_ch0..3, epoch_start/end, last_of_epoch
// config  | wr_en               | wr_index, wr_data
//
// an item that closes an epoch goes through set-up (the multiply state, then
// two divisions), then each result is a store read followed by an output
// register load, with no new read until the previous one is loaded.
// reset loads the configuration defaults and clears the control state;
// the frame store is not cleared. a stalled output holds the emission;
// input waits until the last frame of the epoch is read from the store.
// ----------------------------------------------------------------------------
module sliding_epoch_framer #(
	parameter int EPOCH_MAX = sef_pkg::EPOCH_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [sef_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [15:0]                         wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sef_pkg::SAMPLE_W-1:0] sample_ch0,
	input  logic signed [sef_pkg::SAMPLE_W-1:0] sample_ch1,
	input  logic signed [sef_pkg::SAMPLE_W-1:0] sample_ch2,
	input  logic signed [sef_pkg::SAMPLE_W-1:0] sample_ch3,
	input  logic                                first_of_chunk,
	input  logic [sef_pkg::TIME_W-1:0]          chunk_start_time,
	input  logic [sef_pkg::TIME_W-1:0]          chunk_end_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sef_pkg::SAMPLE_W-1:0] epoch_ch0,
	output logic signed [sef_pkg::SAMPLE_W-1:0] epoch_ch1,
	output logic signed [sef_pkg::SAMPLE_W-1:0] epoch_ch2,
	output logic signed [sef_pkg::SAMPLE_W-1:0] epoch_ch3,
	output logic [sef_pkg::TIME_W-1:0]          epoch_start,
	output logic [sef_pkg::TIME_W-1:0]          epoch_end,
	output logic                                last_of_epoch
);
	import sef_pkg::*;

	localparam int AW = $clog2(EPOCH_MAX);
	localparam int KW = $clog2(EPOCH_MAX + 1);

	// configuration
	logic [RATE_W-1:0] rate_q;
	logic [LEN_W-1:0]  len_q;
	logic [STEP_W-1:0] step_q;

	// stream state
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] origin_q;
	logic [TIME_W-1:0] prev_end_q;
	logic [AW-1:0]     base_q;

	// emission
	state_t                   state_q, state_n;
	logic [KW-1:0]            elen_q;
	logic [AW-1:0]            ebase_q;
	logic [CNT_W+STEP_W-1:0]  prod_q;
	logic [TIME_W-1:0]        t0_q, t1_q;
	logic [KW-1:0]            k_q;
	logic                     pend_s1;
	logic                     last_s1;
	logic                     ov_q;
	frame_t                   odata_q;
	logic [TIME_W-1:0]        ostart_q, oend_q;
	logic                     olast_q;

	logic [KW-1:0]     len_eff;
	logic [STEP_W-1:0] step_eff;
	logic [RATE_W-1:0] rate_eff;
	logic [FILL_W-1:0] len16;
	logic              acc, restart, take, emit, shrink, issue, k_last;
	logic [FILL_W-1:0] fill_a, fill_b, fill_c, fill_n;
	logic [CNT_W-1:0]  cnt_a;
	logic [AW:0]       wsum, rsum, bsum;
	logic [AW-1:0]     waddr, raddr, base_n;
	div_req_t          div_req;
	logic              div_done;
	logic [QUOT_W-1:0] div_quot;
	logic [QUOT_W-1:0] tsum;
	frame_t            wdata, rdata;

	always_comb begin
		if (len_q == '0) begin
			len_eff = KW'(1);
		end else if (len_q > LEN_W'(EPOCH_MAX)) begin
			len_eff = KW'(EPOCH_MAX);
		end else begin
			len_eff = len_q[KW-1:0];
		end
		step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
		rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
		len16    = FILL_W'(len_eff);
	end

	// accept path
	always_comb begin
		acc     = in_valid && in_ready;
		restart = first_of_chunk && (chunk_start_time != prev_end_q);
		fill_a  = restart ? '0 : fill_q;
		cnt_a   = restart ? '0 : cnt_q;
		fill_b  = (fill_a >= len16 && fill_a >= step_eff) ? '0 : fill_a;
		take    = fill_b < len16;
		fill_c  = fill_b + 1'b1;
		emit    = take && (fill_c == len16);
		shrink  = step_eff < len16;
		fill_n  = (emit && shrink) ? (len16 - step_eff) : fill_c;
		wsum    = (AW+1)'(base_q) + (AW+1)'(fill_b[AW-1:0]);
		waddr   = (wsum >= (AW+1)'(EPOCH_MAX)) ? AW'(wsum - (AW+1)'(EPOCH_MAX)) : wsum[AW-1:0];
		bsum    = (AW+1)'(base_q) + (AW+1)'(step_eff[AW-1:0]);
		base_n  = (bsum >= (AW+1)'(EPOCH_MAX)) ? AW'(bsum - (AW+1)'(EPOCH_MAX)) : bsum[AW-1:0];
		wdata   = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RST;
			len_q  <= LEN_RST;
			step_q <= STEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_RATE: rate_q <= wr_data[RATE_W-1:0];
				REG_LEN:  len_q  <= wr_data[LEN_W-1:0];
				REG_STEP: step_q <= wr_data[STEP_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			cnt_q      <= '0;
			origin_q   <= '0;
			prev_end_q <= '0;
			base_q     <= '0;
		end else if (acc) begin
			if (restart) begin
				origin_q <= chunk_start_time;
			end
			if (first_of_chunk) begin
				prev_end_q <= chunk_end_time;
			end
			fill_q <= fill_n;
			cnt_q  <= emit ? cnt_a + 1'b1 : cnt_a;
			if (emit && shrink) begin
				base_q <= base_n;
			end
		end
	end

	// epoch set-up, latched when the closing item is taken; time stamps latched as each division is done
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			prod_q  <= cnt_a * step_eff;
			elen_q  <= len_eff;
			ebase_q <= base_q;
		end
		if (state_q == ST_DIV0 && div_done) begin
			t0_q <= tsum[TIME_W-1:0];
		end
		if (state_q == ST_DIV1 && div_done) begin
			t1_q <= tsum[TIME_W-1:0];
		end
	end

	assign tsum = QUOT_W'(origin_q) + div_quot;

	// fsm
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (acc && emit) state_n = ST_MUL;
			ST_MUL:  state_n = ST_DIV0;
			ST_DIV0: if (div_done) state_n = ST_DIV1;
			ST_DIV1: if (div_done) state_n = ST_EMIT;
			ST_EMIT: if (issue && k_last) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		div_req.start = (state_q == ST_MUL) || (state_q == ST_DIV0 && div_done);
		div_req.num   = (state_q == ST_MUL) ? NUM_W'(prod_q)
		                                    : NUM_W'(prod_q) + NUM_W'(elen_q);
		issue         = (state_q == ST_EMIT) && !pend_s1 && (!ov_q || out_ready);
		k_last        = (k_q == elen_q - 1'b1);
		rsum          = (AW+1)'(ebase_q) + (AW+1)'(k_q[AW-1:0]);
		raddr         = (rsum >= (AW+1)'(EPOCH_MAX)) ? AW'(rsum - (AW+1)'(EPOCH_MAX))
		                                             : rsum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_s1 <= issue;
			last_s1 <= issue && k_last;
			if (acc && emit) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (pend_s1) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// output register, loaded in the cycle after the store read
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			odata_q  <= rdata;
			ostart_q <= t0_q;
			oend_q   <= t1_q;
			olast_q  <= last_s1;
		end
	end

	sef_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (rate_eff),
		.done    (div_done),
		.quot    (div_quot)
	);

	sef_store #(
		.DEPTH (EPOCH_MAX),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (acc && take),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_valid     = ov_q;
	assign epoch_ch0     = odata_q[SAMPLE_W-1:0];
	assign epoch_ch1     = odata_q[2*SAMPLE_W-1:SAMPLE_W];
	assign epoch_ch2     = odata_q[3*SAMPLE_W-1:2*SAMPLE_W];
	assign epoch_ch3     = odata_q[4*SAMPLE_W-1:3*SAMPLE_W];
	assign epoch_start   = ostart_q;
	assign epoch_end     = oend_q;
	assign last_of_epoch = olast_q;

endmodule

>>> sv/sef_checker.sv
// ----------------------------------------------------------------------------
// sef_checker
// Port-level checks of the sliding epoch framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sef_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         last_of_epoch,
	input logic [sef_pkg::TIME_W-1:0]   epoch_start
);
	import sef_pkg::*;

	// no new item while an epoch is still being emitted
	`SEF_ASSERT_IMP(a_no_input_mid_epoch, clk, arst_n, out_valid && !last_of_epoch, !in_ready, "input ready in the middle of an epoch")

	// a fresh epoch needs the time stamp divisions first
	`SEF_ASSERT_NXT(a_no_instant_epoch, clk, arst_n, in_valid && in_ready, !(out_valid && !last_of_epoch), "epoch frame right after an item")

	// stalled result stays valid and keeps its start time stamp
	`SEF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(epoch_start), "stalled result changed")

endmodule

bind sliding_epoch_framer sef_checker u_sef_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.last_of_epoch (last_of_epoch),
	.epoch_start   (epoch_start)
);
